/* hdl/crcfc_pkg.sv */
// crcfc_pkg: shared types, codes and the byte-wise crc update for the frame checker
// used by crcfc_cfg_regs and crc_frame_checker_unit; no dependencies
package crcfc_pkg;

	localparam int DataW = 8;
	localparam int PosW  = 9;
	localparam int CrcW  = 16;
	localparam int OutW  = 16;

	localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

	// register indexes on the configuration port
	localparam logic [2:0] REG_RF_MODE       = 3'd0;
	localparam logic [2:0] REG_START_ONE     = 3'd1;
	localparam logic [2:0] REG_START_TWO     = 3'd2;
	localparam logic [2:0] REG_RF_START      = 3'd3;
	localparam logic [2:0] REG_LEN_CHECK_ON  = 3'd4;
	localparam logic [2:0] REG_EXPECTED_LEN  = 3'd5;

	// verdict codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_START  = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;
	localparam logic [1:0] ERR_CRC    = 2'd3;

	typedef struct packed {
		logic             rf_mode;
		logic [DataW-1:0] start_byte_one;
		logic [DataW-1:0] start_byte_two;
		logic [DataW-1:0] rf_start_byte;
		logic             length_check_on;
		logic [DataW-1:0] expected_length;
	} cfg_t;

	// crc-16/ccitt-false, one byte, poly 0x1021, msb first
	function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
			input logic [DataW-1:0] b);
		logic [7:0]      x;
		logic [CrcW-1:0] r;
		x = crc[15:8] ^ b;
		x = x ^ {4'd0, x[7:4]};
		r = {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
		return r;
	endfunction

endpackage

/* hdl/crc_frame_checker_unit.sv */
// crc_frame_checker_unit: top level of the byte-serial receive frame checker
// depends on crcfc_pkg and crcfc_cfg_regs
//
// usage:
//   s_* carries one received byte per beat; s_tuser marks the first byte of a frame.
//   m_* carries one verdict per checked frame: ok flag, error code and length byte.
//   the cfg_we/cfg_index/cfg_data port writes the mode, start markers and length
//   check; write it only while no frame bytes are in flight.
// timing:
//   a byte is taken into an input register and judged there; the closing beat's verdict
//   goes into the result register (m_tvalid) when that beat advances, which waits while
//   an earlier verdict is still held there with m_tready low; one byte per cycle is
//   sustained while no verdict stalls, and the crc update is a single byte-wise xor step.
// reset:
//   arst_n clears the configuration, the frame state (crc back to 0xffff) and both
//   valid flags; no verdict is pending after reset.
// stall:
//   while m_tready is low and a verdict waits, the input register keeps taking bytes
//   until a second verdict would be produced; then s_tready drops until m_* drains.
module crc_frame_checker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [crcfc_pkg::DataW-1:0]   s_tdata,   // [7:0] data_byte
	input  logic                          s_tuser,   // [0] frame_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [crcfc_pkg::OutW-1:0]    m_tdata,   // [0] frame_ok, [2:1] error_code,
	                                                 // [10:3] payload_length, rest zero
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [crcfc_pkg::DataW-1:0]   cfg_data
);
	import crcfc_pkg::*;

	cfg_t cfg;

	crcfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	logic             valid_s1;
	logic [DataW-1:0] byte_s1;
	logic             start_s1;

	// frame state
	logic             in_frame_q;
	logic [PosW-1:0]  pos_q;
	logic [DataW-1:0] len_q;
	logic [CrcW-1:0]  crc_q;
	logic [DataW-1:0] crc_low_q;

	// result register
	logic             out_valid_q;
	logic [1:0]       out_err_q;
	logic [DataW-1:0] out_len_q;

	// judged byte
	logic             emit;
	logic [1:0]       emit_err;
	logic [DataW-1:0] emit_len;
	logic             in_frame_d;
	logic [PosW-1:0]  pos_d;
	logic [DataW-1:0] len_d;
	logic [CrcW-1:0]  crc_d;
	logic [DataW-1:0] crc_low_d;
	logic             advance;

	logic             open_e;
	logic [DataW-1:0] len_e;
	logic [CrcW-1:0]  crc_e;
	logic [DataW-1:0] crc_low_e;
	logic [PosW-1:0]  pos_e;
	logic [PosW-1:0]  hdr;
	logic [PosW-1:0]  crc_low_pos;
	logic [DataW-1:0] want;

	always_comb begin
		// a start beat reopens the frame from scratch
		open_e    = start_s1 | in_frame_q;
		len_e     = start_s1 ? '0 : len_q;
		crc_e     = start_s1 ? CrcInit : crc_q;
		crc_low_e = start_s1 ? '0 : crc_low_q;
		pos_e     = start_s1 ? '0 : pos_q;

		hdr         = cfg.rf_mode ? PosW'(1) : PosW'(2);
		crc_low_pos = hdr + PosW'(1) + PosW'(len_e);
		want        = cfg.rf_mode ? cfg.rf_start_byte :
		              ((pos_e == '0) ? cfg.start_byte_one : cfg.start_byte_two);

		emit       = 1'b0;
		emit_err   = ERR_NONE;
		emit_len   = '0;
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		len_d      = len_q;
		crc_d      = crc_q;
		crc_low_d  = crc_low_q;

		if (open_e) begin
			in_frame_d = 1'b1;
			pos_d      = pos_e + PosW'(1);
			len_d      = len_e;
			crc_d      = crc_e;
			crc_low_d  = crc_low_e;
			if (pos_e < hdr) begin
				if (byte_s1 != want) begin
					emit     = 1'b1;
					emit_err = ERR_START;
				end
			end else if (pos_e == hdr) begin
				len_d = byte_s1;
				if (cfg.length_check_on && byte_s1 != cfg.expected_length) begin
					emit     = 1'b1;
					emit_err = ERR_LENGTH;
					emit_len = byte_s1;
				end
			end else if (pos_e < crc_low_pos) begin
				crc_d = crc_update(crc_e, byte_s1);
			end else if (pos_e == crc_low_pos) begin
				crc_low_d = byte_s1;
			end else begin
				// anything past the low crc byte is the high crc byte
				emit     = 1'b1;
				emit_err = ({byte_s1, crc_low_e} == crc_e) ? ERR_NONE : ERR_CRC;
				emit_len = len_e;
			end
			if (emit) begin
				in_frame_d = 1'b0;
			end
		end
	end

	// the judged beat moves on unless its verdict finds the result register full and m_tready low
	assign advance  = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			len_q      <= '0;
			crc_q      <= CrcInit;
			crc_low_q  <= '0;
		end else if (advance) begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			crc_q      <= crc_d;
			crc_low_q  <= crc_low_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_err_q <= emit_err;
			out_len_q <= emit_len;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutW - DataW - 3){1'b0}}, out_len_q, out_err_q,
	                   out_err_q == ERR_NONE};

endmodule

/* hdl/crcfc_cfg_regs.sv */
// crcfc_cfg_regs: configuration register file of the frame checker
// depends on crcfc_pkg for the register indexes and cfg_t
module crcfc_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [crcfc_pkg::DataW-1:0] cfg_data,
	output crcfc_pkg::cfg_t           cfg
);
	import crcfc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RF_MODE:      cfg_q.rf_mode         <= cfg_data[0];
				REG_START_ONE:    cfg_q.start_byte_one  <= cfg_data;
				REG_START_TWO:    cfg_q.start_byte_two  <= cfg_data;
				REG_RF_START:     cfg_q.rf_start_byte   <= cfg_data;
				REG_LEN_CHECK_ON: cfg_q.length_check_on <= cfg_data[0];
				REG_EXPECTED_LEN: cfg_q.expected_length <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* verif/crc_frame_checker_unit_test.sv */
// crc_frame_checker_unit_test: self-checking testbench for the byte-serial crc frame checker
// drives byte beats with random gaps, predicts each verdict and compares it on the m_* side
// depends on crcfc_pkg and crc_frame_checker_unit
module crc_frame_checker_unit_test;
	import crcfc_pkg::*;

	localparam int HoldCycles = 400;
	localparam int StallLimit = 4000;
	localparam int ByteTarget = 2000;

	typedef enum int {
		INTACT, BAD_MARKER_A, BAD_MARKER_B, BAD_LENGTH, BAD_CRC_LOW, BAD_CRC_HIGH, CUT_SHORT
	} flaw_e;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
		logic [7:0] plen;
	} verdict_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [DataW-1:0] s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OutW-1:0]  m_tdata;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [DataW-1:0] cfg_data = '0;

	// mirrored registers and frame state of the checker
	cfg_t             regs_mirror = '0;
	logic             framing = 1'b0;
	logic [PosW-1:0]  position = '0;
	logic [7:0]       len_byte = '0;
	logic [CrcW-1:0]  crc_acc = CrcInit;
	logic [7:0]       crc_low_byte = '0;

	verdict_t pending_verdicts[$];
	int       fault_count = 0;
	int       bytes_sent = 0;
	int       idle_cycles = 0;
	bit       calm_phase = 1'b0;
	bit       hold_request = 1'b0;

	always #6 clk = ~clk;

	crc_frame_checker_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bit-serial crc-16, poly 0x1021, msb first
	function automatic logic [CrcW-1:0] crc_ccitt_byte(input logic [CrcW-1:0] c,
			input logic [7:0] b);
		logic [CrcW-1:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
		return r;
	endfunction

	task automatic close_frame(input logic [1:0] code, input logic [7:0] plen);
		pending_verdicts.push_back('{ok: (code == ERR_NONE), code: code, plen: plen});
		framing = 1'b0;
	endtask

	task automatic judge_byte(input logic [7:0] b, input logic start);
		int         pos;
		int         hdr;
		logic [7:0] want;
		if (start) begin
			framing = 1'b1;
			position = '0;
			len_byte = '0;
			crc_acc = CrcInit;
			crc_low_byte = '0;
		end else if (!framing)
			return;
		hdr = regs_mirror.rf_mode ? 1 : 2;
		pos = position;
		position = position + 1'b1;
		if (pos < hdr) begin
			want = regs_mirror.rf_mode ? regs_mirror.rf_start_byte :
				(pos == 0 ? regs_mirror.start_byte_one : regs_mirror.start_byte_two);
			if (b != want)
				close_frame(ERR_START, 8'd0);
		end else if (pos == hdr) begin
			len_byte = b;
			if (regs_mirror.length_check_on && b != regs_mirror.expected_length)
				close_frame(ERR_LENGTH, b);
		end else if (pos < hdr + 1 + len_byte)
			crc_acc = crc_ccitt_byte(crc_acc, b);
		else if (pos == hdr + 1 + len_byte)
			crc_low_byte = b;
		else
			// anything past the low crc byte is taken as the high byte
			close_frame(({b, crc_low_byte} == crc_acc) ? ERR_NONE : ERR_CRC, len_byte);
	endtask

	always @(posedge clk) begin : monitor
		verdict_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				judge_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (pending_verdicts.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected verdict beat: m_tdata=%h", m_tdata);
				end else begin
					want = pending_verdicts.pop_front();
					if (m_tdata[0] !== want.ok || m_tdata[2:1] !== want.code ||
							m_tdata[10:3] !== want.plen) begin
						fault_count++;
						if (fault_count <= 10)
							$display("verdict mismatch: expected ok=%0d code=%0d len=%0d, got ok=%0d code=%0d len=%0d",
								want.ok, want.code, want.plen,
								m_tdata[0], m_tdata[2:1], m_tdata[10:3]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= StallLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// receiver side: random stalls, or one long hold-off when asked
	always begin : receiver
		@(posedge clk);
		if (hold_request) begin
			hold_request = 1'b0;
			m_tready <= 1'b0;
			repeat (HoldCycles) @(posedge clk);
		end else
			m_tready <= calm_phase || ($urandom_range(99) >= 11);
	end

	task automatic send_byte(input logic [7:0] b, input logic start);
		while (!calm_phase && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// wait until every verdict is in and the input register has emptied
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		put_reg(REG_RF_MODE, {7'd0, c.rf_mode});
		put_reg(REG_START_ONE, c.start_byte_one);
		put_reg(REG_START_TWO, c.start_byte_two);
		put_reg(REG_RF_START, c.rf_start_byte);
		put_reg(REG_LEN_CHECK_ON, {7'd0, c.length_check_on});
		put_reg(REG_EXPECTED_LEN, c.expected_length);
		cfg_we <= 1'b0;
		regs_mirror = c;
	endtask

	function automatic logic [7:0] flip_mask();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] pick_marker();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		c.rf_mode = 1'($urandom_range(1));
		c.start_byte_one = pick_marker();
		c.start_byte_two = pick_marker();
		c.rf_start_byte = pick_marker();
		c.length_check_on = ($urandom_range(3) == 0);
		c.expected_length = ($urandom_range(19) == 0) ? 8'($urandom_range(40, 255)) :
			8'($urandom_range(0, 6));
		return c;
	endfunction

	// mostly short payloads, now and then a long one
	function automatic int pick_length();
		return ($urandom_range(49) == 0) ? $urandom_range(11, 255) : $urandom_range(0, 10);
	endfunction

	function automatic flaw_e pick_flaw();
		return flaw_e'($urandom_range(CUT_SHORT));
	endfunction

	task automatic send_frame(input int plen, input flaw_e flaw);
		logic [7:0]      frame_bytes[$];
		logic [7:0]      lenb;
		logic [7:0]      d;
		logic [CrcW-1:0] crc;
		int              keep;
		int              hdr;
		hdr = regs_mirror.rf_mode ? 1 : 2;
		crc = CrcInit;
		if (regs_mirror.rf_mode)
			frame_bytes.push_back(regs_mirror.rf_start_byte ^
				((flaw == BAD_MARKER_A || flaw == BAD_MARKER_B) ? flip_mask() : 8'h00));
		else begin
			frame_bytes.push_back(regs_mirror.start_byte_one ^
				(flaw == BAD_MARKER_A ? flip_mask() : 8'h00));
			frame_bytes.push_back(regs_mirror.start_byte_two ^
				(flaw == BAD_MARKER_B ? flip_mask() : 8'h00));
		end
		lenb = 8'(plen);
		if (regs_mirror.length_check_on)
			lenb = regs_mirror.expected_length ^ (flaw == BAD_LENGTH ? flip_mask() : 8'h00);
		frame_bytes.push_back(lenb);
		for (int i = 0; i < lenb; i++) begin
			d = 8'($urandom);
			crc = crc_ccitt_byte(crc, d);
			frame_bytes.push_back(d);
		end
		frame_bytes.push_back(crc[7:0] ^ (flaw == BAD_CRC_LOW ? flip_mask() : 8'h00));
		frame_bytes.push_back(crc[15:8] ^ (flaw == BAD_CRC_HIGH ? flip_mask() : 8'h00));
		keep = frame_bytes.size();
		// a couple of trailing bytes after a length miss should be ignored
		if (flaw == BAD_LENGTH && keep > hdr + 3)
			keep = hdr + 3;
		if (flaw == CUT_SHORT)
			keep = $urandom_range(1, keep - 1);
		for (int i = 0; i < keep; i++)
			send_byte(frame_bytes[i], i == 0);
	endtask

	task automatic test_directed_cases();
		// reset config: wired, all markers zero, no length check
		send_frame(0, INTACT);
		send_byte(8'hFF, 1'b0);
		send_frame(0, BAD_MARKER_B);
		send_frame(1, CUT_SHORT);
		// open a wired frame, then switch to rf mode with the frame still open
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		settle();
		load_config('{rf_mode: 1'b1, start_byte_one: 8'hFF, start_byte_two: 8'hFF,
			rf_start_byte: 8'hFF, length_check_on: 1'b1, expected_length: 8'd2});
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_frame(0, BAD_LENGTH);
		send_frame(0, BAD_CRC_HIGH);
		settle();
	endtask

	task automatic test_register_extremes();
		cfg_t c;
		int   frames;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: c = '{1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00};
				1: c = '{1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1, 8'hFF};
				2: c = '{1'b1, 8'h00, 8'h00, 8'hFF, 1'b1, 8'h00};
				default: c = '{1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0, 8'hFF};
			endcase
			load_config(c);
			frames = (c.length_check_on && c.expected_length == 8'hFF) ? 2 : 8;
			repeat (frames) send_frame(pick_length(), pick_flaw());
			settle();
		end
	endtask

	task automatic test_calm_stretch();
		calm_phase = 1'b1;
		repeat (40) send_frame(pick_length(), ($urandom_range(3) == 0) ? pick_flaw() : INTACT);
		settle();
		calm_phase = 1'b0;
	endtask

	task automatic test_receiver_hold();
		cfg_t c;
		c = random_config();
		c.length_check_on = 1'b0;
		load_config(c);
		hold_request = 1'b1;
		// keep offering short frames so verdicts back up and s_tready drops
		repeat (16) send_frame(0, INTACT);
		settle();
	endtask

	task automatic test_random_traffic();
		int frames;
		int roll;
		frames = 0;
		while (bytes_sent < ByteTarget) begin
			if (frames % 25 == 0) begin
				settle();
				load_config(random_config());
			end
			frames++;
			roll = $urandom_range(99);
			if (roll < 70)
				send_frame(pick_length(), INTACT);
			else if (roll < 88)
				send_frame(pick_length(), pick_flaw());
			else if (roll < 94)
				send_byte(8'($urandom), 1'b0);
			else
				send_byte(8'($urandom), 1'b1);
		end
		settle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_calm_stretch();
		test_receiver_hold();
		test_random_traffic();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
